[src/ldpp_pkg.sv]
// Shared types and constants of the lidar data packet parser.
// Used by the front parser, the result queue user and the top level.
package ldpp_pkg;

  localparam int          POS_W        = 11;
  localparam logic [10:0] POS_MAX      = 11'd2047;
  localparam int          FOOTER_BYTES = 6;
  localparam logic [7:0]  FLAG_BYTE0   = 8'hFF;
  localparam logic [7:0]  FLAG_BYTE1   = 8'hEE;
  localparam logic [15:0] EXP_LEN_RST  = 16'd1248;

  localparam logic        KIND_POINT   = 1'b0;
  localparam logic        KIND_STATUS  = 1'b1;

  localparam logic [1:0]  STATUS_GOOD    = 2'd0;
  localparam logic [1:0]  STATUS_BAD_LEN = 2'd1;
  localparam logic [1:0]  STATUS_NO_FLAG = 2'd2;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  block_index;
    logic [4:0]  channel_index;
    logic [15:0] block_ident;
    logic [15:0] azimuth_count;
    logic [15:0] distance_count;
    logic [7:0]  intensity;
    logic [1:0]  frame_status;
    logic [31:0] timestamp;
    logic [15:0] factory_bytes;
    logic        last_result;
  } result_t;

endpackage

[src/ldpp_front.sv]
// Front parser: accepts frame bytes, tracks position and checks, builds result records.
// Depends on ldpp_pkg; pushes records into the result queue.
module ldpp_front #(
  parameter int HEADER_BYTES = 42,
  parameter int BLOCKS       = 12,
  parameter int CHANNELS     = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic [15:0]       in_frame_length,
  input  logic              in_last_byte,
  input  logic              q_full,
  output logic              q_push,
  output ldpp_pkg::result_t q_data
);

  localparam int          BlockBytes  = 4 + 3 * CHANNELS;
  localparam int          KW          = $clog2(BlockBytes);
  localparam logic [31:0] HdrStart    = 32'(HEADER_BYTES);
  localparam logic [31:0] FooterStart = 32'(HEADER_BYTES + BLOCKS * BlockBytes);
  localparam logic [31:0] FooterEnd   = 32'(HEADER_BYTES + BLOCKS * BlockBytes
                                            + ldpp_pkg::FOOTER_BYTES);
  localparam logic [KW-1:0] KLast     = KW'(BlockBytes - 1);

  logic [15:0] exp_len_r;
  logic [ldpp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        flag_ok_r, flag_ok_nxt;
  logic        first_ok_r, first_ok_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [1:0]  t_r, t_nxt;
  logic [4:0]  ch_r, ch_nxt;
  logic [3:0]  blk_r, blk_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] az_r, az_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [47:0] footer_r, footer_nxt;

  logic        accept;
  logic [31:0] pos_ext;
  logic        in_blocks;
  logic        in_footer;
  logic [2:0]  fi;
  logic        point;
  logic [1:0]  status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pos_ext  = 32'(pos_r);
  assign in_blocks = (pos_ext >= HdrStart) && (pos_ext < FooterStart);
  assign in_footer = (pos_ext >= FooterStart) && (pos_ext < FooterEnd);
  assign fi        = 3'(pos_ext - FooterStart);

  always_comb begin
    len_ok_nxt   = (pos_r == '0) ? (in_frame_length == exp_len_r) : len_ok_r;
    first_ok_nxt = (pos_ext == HdrStart) ? (in_data_byte == ldpp_pkg::FLAG_BYTE0)
                                         : first_ok_r;
    flag_ok_nxt  = (pos_ext == HdrStart + 32'd1)
                   ? (first_ok_r && (in_data_byte == ldpp_pkg::FLAG_BYTE1)) : flag_ok_r;
    ident_nxt  = ident_r;
    az_nxt     = az_r;
    dist_nxt   = dist_r;
    footer_nxt = footer_r;
    point      = 1'b0;
    if (in_blocks) begin
      unique case (k_r)
        KW'(0): ident_nxt = {ident_r[15:8], in_data_byte};
        KW'(1): ident_nxt = {in_data_byte, ident_r[7:0]};
        KW'(2): az_nxt    = {az_r[15:8], in_data_byte};
        KW'(3): az_nxt    = {in_data_byte, az_r[7:0]};
        default: begin
          unique case (t_r)
            2'd0:    dist_nxt = {dist_r[15:8], in_data_byte};
            2'd1:    dist_nxt = {in_data_byte, dist_r[7:0]};
            default: point = len_ok_nxt && flag_ok_nxt;
          endcase
        end
      endcase
    end else if (in_footer) begin
      footer_nxt = footer_r | (48'(in_data_byte) << {fi, 3'b000});
    end

    pos_nxt = pos_r;
    k_nxt   = k_r;
    t_nxt   = t_r;
    ch_nxt  = ch_r;
    blk_nxt = blk_r;
    if (pos_r < ldpp_pkg::POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
      if (in_blocks) begin
        if (k_r == KLast) begin
          k_nxt   = '0;
          t_nxt   = 2'd0;
          ch_nxt  = 5'd0;
          blk_nxt = blk_r + 4'd1;
        end else begin
          k_nxt = k_r + 1'b1;
          if (k_r >= KW'(4)) begin
            if (t_r == 2'd2) begin
              t_nxt  = 2'd0;
              ch_nxt = ch_r + 5'd1;
            end else begin
              t_nxt = t_r + 2'd1;
            end
          end
        end
      end
    end

    priority if (!len_ok_nxt) begin
      status = ldpp_pkg::STATUS_BAD_LEN;
    end else if (!flag_ok_nxt) begin
      status = ldpp_pkg::STATUS_NO_FLAG;
    end else begin
      status = ldpp_pkg::STATUS_GOOD;
    end

    q_data = '0;
    if (in_last_byte) begin
      q_data.result_kind  = ldpp_pkg::KIND_STATUS;
      q_data.frame_status = status;
      if (status == ldpp_pkg::STATUS_GOOD) begin
        q_data.timestamp     = footer_nxt[31:0];
        q_data.factory_bytes = footer_nxt[47:32];
      end
      q_data.last_result = 1'b1;
    end else begin
      q_data.result_kind    = ldpp_pkg::KIND_POINT;
      q_data.block_index    = blk_r;
      q_data.channel_index  = ch_r;
      q_data.block_ident    = ident_nxt;
      q_data.azimuth_count  = az_nxt;
      q_data.distance_count = dist_nxt;
      q_data.intensity      = in_data_byte;
    end
    q_push = accept && (in_last_byte || point);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r  <= ldpp_pkg::EXP_LEN_RST;
      pos_r      <= '0;
      len_ok_r   <= 1'b0;
      flag_ok_r  <= 1'b0;
      first_ok_r <= 1'b0;
      k_r        <= '0;
      t_r        <= 2'd0;
      ch_r       <= 5'd0;
      blk_r      <= 4'd0;
      footer_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        exp_len_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_last_byte) begin
          pos_r      <= '0;
          len_ok_r   <= 1'b0;
          flag_ok_r  <= 1'b0;
          first_ok_r <= 1'b0;
          k_r        <= '0;
          t_r        <= 2'd0;
          ch_r       <= 5'd0;
          blk_r      <= 4'd0;
          footer_r   <= '0;
        end else begin
          pos_r      <= pos_nxt;
          len_ok_r   <= len_ok_nxt;
          flag_ok_r  <= flag_ok_nxt;
          first_ok_r <= first_ok_nxt;
          k_r        <= k_nxt;
          t_r        <= t_nxt;
          ch_r       <= ch_nxt;
          blk_r      <= blk_nxt;
          footer_r   <= footer_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ident_r <= ident_nxt;
      az_r    <= az_nxt;
      dist_r  <= dist_nxt;
    end
  end

endmodule

[src/ldpp_fifo.sv]
// Small register queue between the front parser and the output stage.
// Standalone; carries any record of WIDTH bits.
module ldpp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_nxt;
      end
      if (pop) begin
        rptr_r <= rptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

[src/ldpp_back.sv]
// Output stage: takes records from the result queue into the output register.
// Depends on ldpp_pkg for the record type.
module ldpp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ldpp_pkg::result_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ldpp_pkg::result_t out_item
);

  logic              valid_r;
  ldpp_pkg::result_t item_r;

  assign q_pop     = !q_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_data;
    end
  end

endmodule

[src/lidar_data_packet_parser_top.sv]
// Lidar data packet parser: parses a frame's bytes into point and status records.
// Top level; instantiates ldpp_front, ldpp_fifo and ldpp_back; uses ldpp_pkg.
//
// The input channel carries one frame byte per transfer with the frame's reported
// length and a mark on its last byte. The output channel carries one point record
// per distance/intensity triplet of a good frame and one status record on the last
// byte of every frame. The cfg port writes the expected frame length; it must be
// written only while no frame is in flight, which the block itself does not enforce.
// One byte can be accepted every clock cycle while the result queue is not full.
// A result passes through the queue and then the output register before it is
// presented on the output.
// The front parser writes records into a FIFO_DEPTH-entry queue; in_ready drops
// only when that queue is full, so a stalled receiver backs up the queue first and
// then holds off the input. The output register keeps its record until transferred.
// Reset clears the frame state and the queue and sets the expected length to 1248.
module lidar_data_packet_parser_top #(
  parameter int HEADER_BYTES = 42,
  parameter int BLOCKS       = 12,
  parameter int CHANNELS     = 32,
  parameter int FIFO_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_frame_length,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [3:0]  out_block_index,
  output logic [4:0]  out_channel_index,
  output logic [15:0] out_block_ident,
  output logic [15:0] out_azimuth_count,
  output logic [15:0] out_distance_count,
  output logic [7:0]  out_intensity,
  output logic [1:0]  out_frame_status,
  output logic [31:0] out_timestamp,
  output logic [15:0] out_factory_bytes,
  output logic        out_last_result
);

  localparam int RW = $bits(ldpp_pkg::result_t);

  logic              q_full, q_empty, q_push, q_pop;
  ldpp_pkg::result_t push_item, head_item, out_item;
  logic [RW-1:0]     head_bits;

  ldpp_front #(
    .HEADER_BYTES(HEADER_BYTES),
    .BLOCKS      (BLOCKS),
    .CHANNELS    (CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_frame_length(in_frame_length),
    .in_last_byte   (in_last_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (push_item)
  );

  ldpp_fifo #(
    .WIDTH(RW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_item),
    .pop      (q_pop),
    .pop_data (head_bits),
    .full     (q_full),
    .empty    (q_empty)
  );

  assign head_item = ldpp_pkg::result_t'(head_bits);

  ldpp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (head_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  assign out_result_kind    = out_item.result_kind;
  assign out_block_index    = out_item.block_index;
  assign out_channel_index  = out_item.channel_index;
  assign out_block_ident    = out_item.block_ident;
  assign out_azimuth_count  = out_item.azimuth_count;
  assign out_distance_count = out_item.distance_count;
  assign out_intensity      = out_item.intensity;
  assign out_frame_status   = out_item.frame_status;
  assign out_timestamp      = out_item.timestamp;
  assign out_factory_bytes  = out_item.factory_bytes;
  assign out_last_result    = out_item.last_result;

endmodule

[dv/ldpp_checker.sv]
`timescale 1ns / 1ps
// Checker for the lidar data packet parser: predicts every record from the accepted bytes.
// Watches the cfg port and both channels of lidar_data_packet_parser_top; uses ldpp_pkg.
module ldpp_checker #(
  parameter int HEADER_BYTES = 42,
  parameter int BLOCKS       = 12,
  parameter int CHANNELS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_frame_length,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [3:0]  out_block_index,
  input  logic [4:0]  out_channel_index,
  input  logic [15:0] out_block_ident,
  input  logic [15:0] out_azimuth_count,
  input  logic [15:0] out_distance_count,
  input  logic [7:0]  out_intensity,
  input  logic [1:0]  out_frame_status,
  input  logic [31:0] out_timestamp,
  input  logic [15:0] out_factory_bytes,
  input  logic        out_last_result,
  output int          failures,
  output int          outstanding
);

  localparam int BLOCK_BYTES  = 4 + 3 * CHANNELS;
  localparam int FOOTER_START = HEADER_BYTES + BLOCKS * BLOCK_BYTES;

  logic [15:0] expected_len = ldpp_pkg::EXP_LEN_RST;
  logic [10:0] byte_pos = '0;
  logic        len_ok = 1'b0;
  logic        flag_ok = 1'b0;
  logic        first_flag_ok = 1'b0;
  logic [3:0]  blk_num = '0;
  logic [4:0]  chan_num = '0;
  logic [15:0] held_ident = '0;
  logic [15:0] held_azimuth = '0;
  logic [15:0] held_distance = '0;
  logic [47:0] footer = '0;
  ldpp_pkg::result_t record_q[$];
  int          fail_count = 0;

  assign failures = fail_count;

  task automatic clear_frame();
    byte_pos      = '0;
    len_ok        = 1'b0;
    flag_ok       = 1'b0;
    first_flag_ok = 1'b0;
    blk_num       = '0;
    chan_num      = '0;
    held_ident    = '0;
    held_azimuth  = '0;
    held_distance = '0;
    footer        = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic [15:0] flen, input logic last);
    int      off;
    int      k;
    int      fi;
    logic    make_point;
    ldpp_pkg::result_t rec;
    make_point = 1'b0;
    rec = '0;
    if (byte_pos == 0) len_ok = (flen == expected_len);
    if (byte_pos == HEADER_BYTES) first_flag_ok = (b == ldpp_pkg::FLAG_BYTE0);
    if (byte_pos == HEADER_BYTES + 1) flag_ok = first_flag_ok && (b == ldpp_pkg::FLAG_BYTE1);
    if (byte_pos >= HEADER_BYTES && byte_pos < FOOTER_START) begin
      off = int'(byte_pos) - HEADER_BYTES;
      k = off % BLOCK_BYTES;
      blk_num = 4'(off / BLOCK_BYTES);
      if (k == 0) begin
        held_ident[7:0] = b;
      end else if (k == 1) begin
        held_ident[15:8] = b;
      end else if (k == 2) begin
        held_azimuth[7:0] = b;
      end else if (k == 3) begin
        held_azimuth[15:8] = b;
      end else begin
        chan_num = 5'((k - 4) / 3);
        case ((k - 4) % 3)
          0: held_distance[7:0] = b;
          1: held_distance[15:8] = b;
          default: make_point = len_ok && flag_ok;
        endcase
      end
    end else if (byte_pos >= FOOTER_START
                 && byte_pos < FOOTER_START + ldpp_pkg::FOOTER_BYTES) begin
      fi = int'(byte_pos) - FOOTER_START;
      footer[8*fi +: 8] = b;
    end

    if (last) begin
      rec.result_kind = ldpp_pkg::KIND_STATUS;
      if (!len_ok) begin
        rec.frame_status = ldpp_pkg::STATUS_BAD_LEN;
      end else if (!flag_ok) begin
        rec.frame_status = ldpp_pkg::STATUS_NO_FLAG;
      end else begin
        rec.frame_status  = ldpp_pkg::STATUS_GOOD;
        rec.timestamp     = footer[31:0];
        rec.factory_bytes = footer[47:32];
      end
      rec.last_result = 1'b1;
      record_q.push_back(rec);
      clear_frame();
    end else begin
      if (byte_pos < ldpp_pkg::POS_MAX) byte_pos = byte_pos + 1'b1;
      if (make_point) begin
        rec.result_kind    = ldpp_pkg::KIND_POINT;
        rec.block_index    = blk_num;
        rec.channel_index  = chan_num;
        rec.block_ident    = held_ident;
        rec.azimuth_count  = held_azimuth;
        rec.distance_count = held_distance;
        rec.intensity      = b;
        record_q.push_back(rec);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ldpp_pkg::result_t want;
    if (!rst_n) begin
      expected_len = ldpp_pkg::EXP_LEN_RST;
      clear_frame();
      record_q.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(in_data_byte, in_frame_length, in_last_byte);
      if (cfg_wr_en) expected_len = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (record_q.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual kind %0d status %0d",
                   $time, out_result_kind, out_frame_status);
          fail_count++;
        end else begin
          want = record_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_result_kind));
          check_field("block_index", 32'(want.block_index), 32'(out_block_index));
          check_field("channel_index", 32'(want.channel_index), 32'(out_channel_index));
          check_field("block_ident", 32'(want.block_ident), 32'(out_block_ident));
          check_field("azimuth_count", 32'(want.azimuth_count), 32'(out_azimuth_count));
          check_field("distance_count", 32'(want.distance_count),
                      32'(out_distance_count));
          check_field("intensity", 32'(want.intensity), 32'(out_intensity));
          check_field("frame_status", 32'(want.frame_status), 32'(out_frame_status));
          check_field("timestamp", want.timestamp, out_timestamp);
          check_field("factory_bytes", 32'(want.factory_bytes), 32'(out_factory_bytes));
          check_field("last_result", 32'(want.last_result), 32'(out_last_result));
        end
      end
    end
    outstanding <= record_q.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the lidar data packet parser testbench: clock, reset, frame stimulus and verdict.
// Instantiates lidar_data_packet_parser_top and ldpp_checker; uses ldpp_pkg.
module testbench;

  localparam int HEADER_BYTES = 42;
  localparam int BLOCKS       = 12;
  localparam int CHANNELS     = 32;
  localparam int BLOCK_BYTES  = 4 + 3 * CHANNELS;
  localparam int FRAME_BYTES  = HEADER_BYTES + BLOCKS * BLOCK_BYTES + ldpp_pkg::FOOTER_BYTES;
  localparam int PHASES       = 5;
  localparam int FRAMES_EACH  = 2;

  localparam int FLAG_RIGHT      = 0;
  localparam int FLAG_BAD_FIRST  = 1;
  localparam int FLAG_BAD_SECOND = 2;
  localparam int FLAG_BAD_BOTH   = 3;

  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_RARE   = 2;
  localparam int READY_BLOCKS = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_frame_length = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [3:0]  out_block_index;
  logic [4:0]  out_channel_index;
  logic [15:0] out_block_ident;
  logic [15:0] out_azimuth_count;
  logic [15:0] out_distance_count;
  logic [7:0]  out_intensity;
  logic [1:0]  out_frame_status;
  logic [31:0] out_timestamp;
  logic [15:0] out_factory_bytes;
  logic        out_last_result;
  int          failures;
  int          outstanding;

  logic [15:0] cur_expected_len = ldpp_pkg::EXP_LEN_RST;
  int          burst_left = 0;
  int          ready_mode = READY_ALWAYS;
  int          ready_run = 0;

  lidar_data_packet_parser_top #(
    .HEADER_BYTES(HEADER_BYTES),
    .BLOCKS      (BLOCKS),
    .CHANNELS    (CHANNELS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_frame_length   (in_frame_length),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_block_index   (out_block_index),
    .out_channel_index (out_channel_index),
    .out_block_ident   (out_block_ident),
    .out_azimuth_count (out_azimuth_count),
    .out_distance_count(out_distance_count),
    .out_intensity     (out_intensity),
    .out_frame_status  (out_frame_status),
    .out_timestamp     (out_timestamp),
    .out_factory_bytes (out_factory_bytes),
    .out_last_result   (out_last_result)
  );

  ldpp_checker #(
    .HEADER_BYTES(HEADER_BYTES),
    .BLOCKS      (BLOCKS),
    .CHANNELS    (CHANNELS)
  ) u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // The receiver picks a new stall pattern for each run of random length.
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode = $urandom_range(READY_ALWAYS, READY_BLOCKS);
      ready_run = $urandom_range(10, 150);
    end
    ready_run--;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_RARE:   out_ready <= ($urandom_range(0, 7) == 0);
      default:      out_ready <= (ready_run % 16) >= 12;
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic [15:0] flen, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800)
                                               : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_frame_length <= flen;
    in_last_byte    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame(input int nbytes, input logic [15:0] flen, input int flag_mode);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      if (i == HEADER_BYTES) begin
        b = (flag_mode == FLAG_BAD_FIRST || flag_mode == FLAG_BAD_BOTH)
            ? ldpp_pkg::FLAG_BYTE0 ^ 8'($urandom_range(1, 255)) : ldpp_pkg::FLAG_BYTE0;
      end else if (i == HEADER_BYTES + 1) begin
        b = (flag_mode == FLAG_BAD_SECOND || flag_mode == FLAG_BAD_BOTH)
            ? ldpp_pkg::FLAG_BYTE1 ^ 8'($urandom_range(1, 255)) : ldpp_pkg::FLAG_BYTE1;
      end
      send_byte(b, flen, i == nbytes - 1);
    end
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_expected_len(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_expected_len = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_frame();
    int          pick;
    int          nbytes;
    int          flag_mode;
    logic [15:0] flen;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      nbytes = $urandom_range(1, HEADER_BYTES + 2);
    end else if (pick < 80) begin
      // The frame ends on the intensity byte of a triplet in the first block.
      nbytes = HEADER_BYTES + 4 + 3 * $urandom_range(0, 3) + 3;
    end else begin
      nbytes = $urandom_range(HEADER_BYTES + 2, HEADER_BYTES + 18);
    end
    pick = $urandom_range(0, 9);
    if (pick < 8) flen = cur_expected_len;
    else if (pick == 8) flen = 16'($urandom);
    else flen = cur_expected_len ^ (16'd1 << $urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 82) flag_mode = FLAG_RIGHT;
    else if (pick < 88) flag_mode = FLAG_BAD_FIRST;
    else if (pick < 94) flag_mode = FLAG_BAD_SECOND;
    else flag_mode = FLAG_BAD_BOTH;
    send_frame(nbytes, flen, flag_mode);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short frames: single bytes with a length match and no flag, wrong lengths at both ends, then two bytes.
    send_byte(8'hFF, ldpp_pkg::EXP_LEN_RST, 1'b1);
    send_byte(8'h00, 16'h0000, 1'b1);
    send_byte(8'hFF, 16'hFFFF, 1'b1);
    send_byte(8'h5A, ldpp_pkg::EXP_LEN_RST, 1'b0);
    send_byte(8'hA5, ldpp_pkg::EXP_LEN_RST, 1'b1);
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: write_expected_len(16'h0000);
        2: write_expected_len(16'hFFFF);
        3: write_expected_len(16'($urandom));
        4: write_expected_len(ldpp_pkg::EXP_LEN_RST);
        default: ;
      endcase
      if (p == 0) send_frame(FRAME_BYTES, cur_expected_len, FLAG_RIGHT);
      for (int f = 0; f < FRAMES_EACH; f++) random_frame();
      in_valid <= 1'b0;
      drain();
    end

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[lidar_data_packet_parser_top.f]
src/ldpp_pkg.sv
src/ldpp_front.sv
src/ldpp_fifo.sv
src/ldpp_back.sv
src/lidar_data_packet_parser_top.sv
dv/ldpp_checker.sv
dv/testbench.sv
